@@ rtl/core/sis_pkg.sv @@
// Shared types and constants for the sparse integer set unit.
package sis_pkg;

  localparam int unsigned VAL_W    = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned UNIVERSE = 1024;

  typedef struct packed {
    logic [2:0]       func;
    logic [VAL_W-1:0] item_value;
    logic [VAL_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
  } out_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_TEST   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SORT   = 3'd4,
    OP_READ   = 3'd5,
    OP_NOP    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_RANGE    = 3'd3,
    ST_POSITION = 3'd4
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LK1,
    S_LK2,
    S_ER1,
    S_RD1,
    S_SR0,
    S_SR1,
    S_SR2,
    S_CP0,
    S_CP1
  } state_e;

endpackage

@@ rtl/core/sparse_integer_set_unit.sv @@
// Sparse integer set unit: top level joining the front queue and the execution back end.
//
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one operation per
// transaction: insert, erase, contains, clear, sort or read at a dense position.
// Output channel (out_valid_o/out_ready_i, out_data_o) returns exactly one
// result per transaction, in order: status, found flag, read value and count.
// A two-entry command queue decouples acceptance from execution.
// Clear and unused codes finish in the idle state; read reads the member RAM;
// contains, insert and erase read the index RAM, then the member RAM, and erase
// then reads the last member and moves it into the freed position. Sort scans
// every value of the universe, then copies the members. One command executes
// at a time; a command holds the back end until its dependent RAM read
// sequence ends. After reset the index RAM is zeroed by a clearing pass,
// during which in_ready_o is low. A stalled receiver holds the result in the
// output register; the queue keeps accepting until it holds two commands.
module sparse_integer_set_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sis_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sis_pkg::out_t out_data_o
);

  sis_pkg::cmd_chan_t cmd;
  logic               pop;
  logic               init_done;

  sis_front u_front (
    .clk_i, .rst_ni, .enable_i(init_done), .in_valid_i, .in_ready_o,
    .in_data_i, .cmd_o(cmd), .pop_i(pop)
  );

  sis_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .pop_o(pop), .init_done_o(init_done),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_init_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !in_ready_o) else $error("input accepted during clearing pass");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.count <= 11'd1024)) else $error("count overflow");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.status == sis_pkg::ST_OK))
    else $error("found with error status");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cmd.valid) else $error("pop from empty queue");

endmodule

@@ rtl/core/sis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sis_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/sis_front.sv @@
// Front end: accepts transactions, decodes the operation, queues commands.
module sis_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enable_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sis_pkg::in_t        in_data_i,
  output sis_pkg::cmd_chan_t  cmd_o,
  input  logic                pop_i
);

  sis_pkg::cmd_t  mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     fill_q;
  sis_pkg::cmd_t  dec;
  logic           push;

  always_comb begin
    dec.value = in_data_i.item_value;
    dec.pos   = in_data_i.position;
    case (in_data_i.func)
      sis_pkg::OP_INSERT: dec.op = sis_pkg::OP_INSERT;
      sis_pkg::OP_ERASE:  dec.op = sis_pkg::OP_ERASE;
      sis_pkg::OP_TEST:   dec.op = sis_pkg::OP_TEST;
      sis_pkg::OP_CLEAR:  dec.op = sis_pkg::OP_CLEAR;
      sis_pkg::OP_SORT:   dec.op = sis_pkg::OP_SORT;
      sis_pkg::OP_READ:   dec.op = sis_pkg::OP_READ;
      default:            dec.op = sis_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o = enable_i && (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.cmd   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      case ({push, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

@@ rtl/core/sis_back.sv @@
// Back end: executes queued commands against the index, member and scratch RAMs.
module sis_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sis_pkg::cmd_chan_t cmd_i,
  output logic               pop_o,
  output logic               init_done_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sis_pkg::out_t      out_data_o
);

  localparam int unsigned VW = sis_pkg::VAL_W;
  localparam int unsigned CW = sis_pkg::CNT_W;

  sis_pkg::state_e state_q, state_d;
  sis_pkg::cmd_t   cmd_q, cmd_d;
  logic [VW-1:0]   p_q, p_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [VW-1:0]   j_q, j_d;
  logic [CW-1:0]   k_q, k_d;
  logic [CW-1:0]   cj_q, cj_d;
  logic            out_valid_q, out_valid_d;
  sis_pkg::out_t   out_q, out_d;

  logic            idx_we, list_we, scr_we;
  logic [VW-1:0]   idx_waddr, idx_wdata, idx_raddr, idx_rdata;
  logic [VW-1:0]   list_waddr, list_wdata, list_raddr, list_rdata;
  logic [VW-1:0]   scr_waddr, scr_wdata, scr_raddr, scr_rdata;

  logic            rs_valid, rs_found, member;
  logic [2:0]      rs_status;
  logic [VW-1:0]   rs_rd, last_pos;

  sis_ram #(.Width(VW), .Depth(sis_pkg::UNIVERSE)) u_idx (
    .clk_i, .we_i(idx_we), .waddr_i(idx_waddr), .wdata_i(idx_wdata),
    .raddr_i(idx_raddr), .rdata_o(idx_rdata)
  );
  sis_ram #(.Width(VW), .Depth(sis_pkg::UNIVERSE)) u_list (
    .clk_i, .we_i(list_we), .waddr_i(list_waddr), .wdata_i(list_wdata),
    .raddr_i(list_raddr), .rdata_o(list_rdata)
  );
  sis_ram #(.Width(VW), .Depth(sis_pkg::UNIVERSE)) u_scr (
    .clk_i, .we_i(scr_we), .waddr_i(scr_waddr), .wdata_i(scr_wdata),
    .raddr_i(scr_raddr), .rdata_o(scr_rdata)
  );

  assign last_pos = VW'(cnt_q - CW'(1));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    p_d        = p_q;
    cnt_d      = cnt_q;
    j_d        = j_q;
    k_d        = k_q;
    cj_d       = cj_q;
    pop_o      = 1'b0;
    idx_we     = 1'b0;
    idx_waddr  = p_q;
    idx_wdata  = p_q;
    idx_raddr  = cmd_i.cmd.value;
    list_we    = 1'b0;
    list_waddr = p_q;
    list_wdata = cmd_q.value;
    list_raddr = cmd_i.cmd.pos;
    scr_we     = 1'b0;
    scr_waddr  = k_q[VW-1:0];
    scr_wdata  = j_q;
    scr_raddr  = cj_q[VW-1:0];
    rs_valid   = 1'b0;
    rs_status  = sis_pkg::ST_OK;
    rs_found   = 1'b0;
    rs_rd      = '0;
    member     = ({1'b0, p_q} < cnt_q) && (list_rdata == cmd_q.value);
    case (state_q)
      sis_pkg::S_INIT: begin
        idx_we    = 1'b1;
        idx_waddr = j_q;
        idx_wdata = '0;
        j_d       = j_q + VW'(1);
        if (j_q == '1) state_d = sis_pkg::S_IDLE;
      end
      sis_pkg::S_IDLE: begin
        if (cmd_i.valid && (!out_valid_q || out_ready_i)) begin
          pop_o = 1'b1;
          cmd_d = cmd_i.cmd;
          case (cmd_i.cmd.op)
            sis_pkg::OP_INSERT, sis_pkg::OP_ERASE, sis_pkg::OP_TEST:
              state_d = sis_pkg::S_LK1;
            sis_pkg::OP_CLEAR: begin
              cnt_d    = '0;
              rs_valid = 1'b1;
            end
            sis_pkg::OP_SORT: begin
              j_d     = '0;
              k_d     = '0;
              state_d = sis_pkg::S_SR0;
            end
            sis_pkg::OP_READ: begin
              if ({1'b0, cmd_i.cmd.pos} < cnt_q) begin
                state_d = sis_pkg::S_RD1;
              end else begin
                rs_status = sis_pkg::ST_POSITION;
                rs_valid  = 1'b1;
              end
            end
            default: rs_valid = 1'b1;
          endcase
        end
      end
      sis_pkg::S_LK1: begin
        p_d        = idx_rdata;
        list_raddr = idx_rdata;
        state_d    = sis_pkg::S_LK2;
      end
      sis_pkg::S_LK2: begin
        state_d = sis_pkg::S_IDLE;
        case (cmd_q.op)
          sis_pkg::OP_INSERT: begin
            rs_valid = 1'b1;
            if (member) begin
              rs_status = sis_pkg::ST_PRESENT;
            end else if (!cnt_q[CW-1]) begin
              idx_we     = 1'b1;
              idx_waddr  = cmd_q.value;
              idx_wdata  = cnt_q[VW-1:0];
              list_we    = 1'b1;
              list_waddr = cnt_q[VW-1:0];
              cnt_d      = cnt_q + CW'(1);
            end
          end
          sis_pkg::OP_ERASE: begin
            if (!member) begin
              rs_status = sis_pkg::ST_ABSENT;
              rs_valid  = 1'b1;
            end else begin
              list_raddr = last_pos;
              state_d    = sis_pkg::S_ER1;
            end
          end
          default: begin
            rs_found = member;
            rs_valid = 1'b1;
          end
        endcase
      end
      sis_pkg::S_ER1: begin
        list_we    = 1'b1;
        list_waddr = p_q;
        list_wdata = list_rdata;
        idx_we     = 1'b1;
        idx_waddr  = list_rdata;
        idx_wdata  = p_q;
        cnt_d      = cnt_q - CW'(1);
        rs_valid   = 1'b1;
        state_d    = sis_pkg::S_IDLE;
      end
      sis_pkg::S_RD1: begin
        rs_rd    = list_rdata;
        rs_valid = 1'b1;
        state_d  = sis_pkg::S_IDLE;
      end
      sis_pkg::S_SR0: begin
        idx_raddr = j_q;
        state_d   = sis_pkg::S_SR1;
      end
      sis_pkg::S_SR1: begin
        p_d        = idx_rdata;
        list_raddr = idx_rdata;
        state_d    = sis_pkg::S_SR2;
      end
      sis_pkg::S_SR2: begin
        if (({1'b0, p_q} < cnt_q) && (list_rdata == j_q)) begin
          scr_we = 1'b1;
          k_d    = k_q + CW'(1);
        end
        j_d = j_q + VW'(1);
        if (j_q == '1) begin
          cj_d    = '0;
          state_d = sis_pkg::S_CP0;
        end else begin
          state_d = sis_pkg::S_SR0;
        end
      end
      sis_pkg::S_CP0: begin
        if (cj_q < k_q) begin
          state_d = sis_pkg::S_CP1;
        end else begin
          rs_valid = 1'b1;
          state_d  = sis_pkg::S_IDLE;
        end
      end
      sis_pkg::S_CP1: begin
        list_we    = 1'b1;
        list_waddr = cj_q[VW-1:0];
        list_wdata = scr_rdata;
        idx_we     = 1'b1;
        idx_waddr  = scr_rdata;
        idx_wdata  = cj_q[VW-1:0];
        cj_d       = cj_q + CW'(1);
        state_d    = sis_pkg::S_CP0;
      end
      default: state_d = sis_pkg::S_IDLE;
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || rs_valid;
    out_d       = out_q;
    if (rs_valid) begin
      out_d.status     = rs_status;
      out_d.found      = rs_found;
      out_d.read_value = rs_rd;
      out_d.count      = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sis_pkg::S_INIT;
      cnt_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      cj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      k_q         <= k_d;
      cj_q        <= cj_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    p_q   <= p_d;
    out_q <= out_d;
  end

  assign init_done_o = (state_q != sis_pkg::S_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sis_checker.sv @@
// Checker for the sparse integer set unit: set predictor and result comparison.
`timescale 1ns / 1ps
module sis_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  sis_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  sis_pkg::out_t out_data_i,
  output int            fail_cnt_o,
  output int            pending_o,
  output int            seen_o
);

  logic [sis_pkg::VAL_W-1:0] pos_of_val [sis_pkg::UNIVERSE];
  logic [sis_pkg::VAL_W-1:0] members [sis_pkg::UNIVERSE];
  logic [sis_pkg::CNT_W-1:0] n_members;
  sis_pkg::out_t expected_q[$];

  function automatic bit holds(logic [sis_pkg::VAL_W-1:0] v);
    logic [sis_pkg::VAL_W-1:0] p;
    p = pos_of_val[v];
    return (p < n_members) && (members[p] == v);
  endfunction

  function automatic sis_pkg::out_t apply_op(sis_pkg::in_t t);
    sis_pkg::out_t r;
    logic [sis_pkg::VAL_W-1:0] p, last;
    int k;
    logic [sis_pkg::VAL_W-1:0] tmp [$];
    r = '0;
    r.status = sis_pkg::ST_OK;
    case (t.func)
      sis_pkg::OP_INSERT: begin
        if (holds(t.item_value)) r.status = sis_pkg::ST_PRESENT;
        else if (n_members < sis_pkg::UNIVERSE) begin
          pos_of_val[t.item_value] = n_members[sis_pkg::VAL_W-1:0];
          members[n_members[sis_pkg::VAL_W-1:0]] = t.item_value;
          n_members++;
        end
      end
      sis_pkg::OP_ERASE: begin
        if (!holds(t.item_value)) r.status = sis_pkg::ST_ABSENT;
        else begin
          p = pos_of_val[t.item_value];
          last = members[sis_pkg::VAL_W'(n_members - 1'b1)];
          members[p] = last;
          pos_of_val[last] = p;
          n_members--;
        end
      end
      sis_pkg::OP_TEST: r.found = holds(t.item_value);
      sis_pkg::OP_CLEAR: n_members = '0;
      sis_pkg::OP_SORT: begin
        for (k = 0; k < sis_pkg::UNIVERSE; k++)
          if (holds(k[sis_pkg::VAL_W-1:0])) tmp.push_back(k[sis_pkg::VAL_W-1:0]);
        for (k = 0; k < tmp.size(); k++) begin
          members[k[sis_pkg::VAL_W-1:0]] = tmp[k];
          pos_of_val[tmp[k]] = k[sis_pkg::VAL_W-1:0];
        end
      end
      sis_pkg::OP_READ: begin
        if (t.position < n_members) r.read_value = members[t.position];
        else r.status = sis_pkg::ST_POSITION;
      end
      default: ;
    endcase
    r.count = n_members;
    return r;
  endfunction

  initial begin
    fail_cnt_o = 0;
    seen_o = 0;
    pending_o = 0;
    n_members = '0;
    for (int i = 0; i < sis_pkg::UNIVERSE; i++) begin
      pos_of_val[i[sis_pkg::VAL_W-1:0]] = '0;
      members[i[sis_pkg::VAL_W-1:0]] = '0;
    end
  end

  always @(posedge clk_i) begin
    sis_pkg::out_t e;
    if (rst_ni && in_valid_i && in_ready_i) expected_q.push_back(apply_op(in_data_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      seen_o++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction %p", out_data_i);
        fail_cnt_o++;
      end else begin
        e = expected_q.pop_front();
        if (e.status !== out_data_i.status) begin
          $error("status exp %0d got %0d", e.status, out_data_i.status); fail_cnt_o++;
        end
        if (e.found !== out_data_i.found) begin
          $error("found exp %0d got %0d", e.found, out_data_i.found); fail_cnt_o++;
        end
        if (e.read_value !== out_data_i.read_value) begin
          $error("read_value exp %0d got %0d", e.read_value, out_data_i.read_value);
          fail_cnt_o++;
        end
        if (e.count !== out_data_i.count) begin
          $error("count exp %0d got %0d", e.count, out_data_i.count); fail_cnt_o++;
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

@@ tb/tb_top.sv @@
// Testbench top for the sparse integer set unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  sis_pkg::in_t  in_data;
  sis_pkg::out_t out_data;
  int   fail_cnt, pending, seen;
  bit   calm;
  int   n_sent;

  sparse_integer_set_unit u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  sis_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .fail_cnt_o(fail_cnt), .pending_o(pending), .seen_o(seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 9);
  end

  // Returns at the falling edge after acceptance with valid still high.
  task automatic send(sis_pkg::op_e op, logic [sis_pkg::VAL_W-1:0] v,
                      logic [sis_pkg::VAL_W-1:0] p);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: op, item_value: v, position: p};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [sis_pkg::VAL_W-1:0] pick_val();
    case ($urandom_range(3))
      0: return sis_pkg::VAL_W'($urandom_range(15));
      1: return 10'h3FF - sis_pkg::VAL_W'($urandom_range(7));
      default: return sis_pkg::VAL_W'($urandom());
    endcase
  endfunction

  initial begin
    int r, n_sort;
    sis_pkg::op_e op;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    calm = 1'b0; n_sent = 0; n_sort = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed
    send(sis_pkg::OP_TEST, 10'd0, 10'd0);
    send(sis_pkg::OP_READ, 10'd0, 10'd0);
    send(sis_pkg::OP_ERASE, 10'd5, 10'd0);
    send(sis_pkg::OP_INSERT, 10'd0, 10'd0);
    send(sis_pkg::OP_INSERT, 10'h3FF, 10'h3FF);
    send(sis_pkg::OP_INSERT, 10'd0, 10'd0);
    send(sis_pkg::OP_INSERT, 10'd512, 10'd0);
    send(sis_pkg::OP_INSERT, 10'd7, 10'd0);
    send(sis_pkg::OP_TEST, 10'h3FF, 10'd0);
    send(sis_pkg::OP_TEST, 10'd6, 10'd0);
    send(sis_pkg::OP_READ, 10'd0, 10'd3);
    send(sis_pkg::OP_READ, 10'd0, 10'd4);
    send(sis_pkg::OP_READ, 10'd0, 10'h3FF);
    send(sis_pkg::OP_ERASE, 10'd0, 10'd0);
    send(sis_pkg::OP_SORT, 10'd0, 10'd0);
    send(sis_pkg::OP_READ, 10'd0, 10'd0);
    send(sis_pkg::OP_READ, 10'd0, 10'd2);
    send(sis_pkg::OP_NOP, 10'h3FF, 10'h3FF);
    send(sis_pkg::op_e'(3'd7), 10'h2AA, 10'h155);
    send(sis_pkg::OP_CLEAR, 10'd0, 10'd0);
    send(sis_pkg::OP_TEST, 10'd7, 10'd0);
    send(sis_pkg::OP_INSERT, 10'd9, 10'd0);
    send(sis_pkg::OP_TEST, 10'd7, 10'd0);
    in_valid <= 1'b0;
    // wait for drain
    while (pending != 0) @(negedge clk);
    // random
    for (int i = 0; i < 800; i++) begin
      calm = (i >= 300 && i < 420);
      r = $urandom_range(99);
      if (r < 30) op = sis_pkg::OP_INSERT;
      else if (r < 48) op = sis_pkg::OP_ERASE;
      else if (r < 68) op = sis_pkg::OP_TEST;
      else if (r < 88) op = sis_pkg::OP_READ;
      else if (r < 92) op = sis_pkg::OP_CLEAR;
      else if (r < 94 && n_sort < 12) begin op = sis_pkg::OP_SORT; n_sort++; end
      else op = sis_pkg::op_e'(3'd6 + 3'($urandom_range(1)));
      send(op, pick_val(),
           (r & 1) ? sis_pkg::VAL_W'($urandom_range(40)) : sis_pkg::VAL_W'($urandom()));
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d operations incl. directed corner cases; %0d results checked.",
             n_sent, seen);
    if (fail_cnt == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
